// ----- src/sarm_pkg.sv -----
`timescale 1ns / 1ps

package sarm_pkg;

    localparam int MAX_CHANNELS = 256;
    localparam int COUNT_BITS   = 16;

    localparam int IDX_W    = $clog2(MAX_CHANNELS);
    localparam int GROUPS   = (MAX_CHANNELS + 63) / 64;
    localparam int GRP_W    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int MASK_W   = GROUPS * 64;
    localparam int NBAD_W   = $clog2(MAX_CHANNELS + 1);
    localparam int EVT_W    = 16;
    localparam int CMP_W    = (COUNT_BITS + 1 > EVT_W) ? COUNT_BITS + 1 : EVT_W;
    localparam int POS_W    = 9;
    localparam int STEP_W   = 8;
    localparam int ADC_W    = 12;
    localparam int LIM_W    = 9;
    localparam int MINEV_W  = 16;
    localparam int CFG_DW   = 16;
    localparam int CFG_IW   = 2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [EVT_W-1:0]      EVT_MAX   = {EVT_W{1'b1}};
    localparam logic [POS_W-1:0]      POS_MAX   = {POS_W{1'b1}};
    localparam logic [STEP_W-1:0]     STEP_MAX  = {STEP_W{1'b1}};

    localparam logic [LIM_W-1:0]   CHANNELS_RESET  = 9'd192;
    localparam logic [STEP_W-1:0]  MIN_STEPS_RESET = 8'd3;
    localparam logic [MINEV_W-1:0] MIN_EVENTS_RESET = 16'd10;

    localparam logic [CFG_IW-1:0] CFG_CHANNELS   = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_MIN_STEPS  = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_MIN_EVENTS = 2'd2;

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_EMPTY  = 2'd1;
    localparam logic [1:0] CMD_CHECK  = 2'd2;

    localparam logic [GRP_W-1:0] GROUP_LAST = GRP_W'(GROUPS - 1);

    typedef logic [COUNT_BITS-1:0] count_t;

    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] run_lo;
        logic [POS_W-1:0] run_hi;
    } inc_t;

    typedef struct packed {
        logic shift;
        logic wrap;
    } chain_t;

    typedef enum logic [2:0] {
        CHK_IDLE,
        CHK_MAX,
        CHK_JUDGE,
        CHK_MASK,
        CHK_EMIT
    } chk_state_t;

endpackage

// ----- src/sarm_cell.sv -----
`timescale 1ns / 1ps

module sarm_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [sarm_pkg::IDX_W-1:0] idx,
    input  logic [sarm_pkg::LIM_W-1:0] limit,
    input  sarm_pkg::inc_t            run_inc,
    input  logic                      shift,
    input  sarm_pkg::count_t          shift_in,
    output sarm_pkg::count_t          count
);
    import sarm_pkg::*;

    count_t            count_reg;
    count_t            count_next;
    logic [POS_W-1:0]  pos_idx;
    logic              in_run;

    assign pos_idx = POS_W'(idx);
    assign in_run  = run_inc.valid && (pos_idx >= run_inc.run_lo)
                     && (pos_idx <= run_inc.run_hi) && (LIM_W'(idx) < limit);

    always_comb
    begin
        count_next = count_reg;
        if (shift)
        begin
            count_next = shift_in;
        end
        else if (in_run && (count_reg != COUNT_MAX))
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

// ----- src/sarm_front.sv -----
`timescale 1ns / 1ps

module sarm_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        sample_en,
    input  logic                        empty_en,
    input  logic                        check_en,
    input  logic [sarm_pkg::ADC_W-1:0]  adc,
    input  logic                        last,
    input  logic [sarm_pkg::STEP_W-1:0] min_equal_steps,
    output sarm_pkg::inc_t              run_inc,
    output logic [sarm_pkg::EVT_W-1:0]  event_total
);
    import sarm_pkg::*;

    logic [ADC_W-1:0]  prev_reg, prev_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [STEP_W-1:0] steps_reg, steps_next;
    logic [POS_W-1:0]  first_reg, first_next;
    logic [POS_W-1:0]  final_reg, final_next;
    logic [EVT_W-1:0]  events_reg, events_next;
    inc_t              inc_reg, inc_next;

    logic              eq_step;
    logic              neq_step;
    logic [STEP_W-1:0] steps_inc;
    logic [STEP_W-1:0] close_steps;
    logic [STEP_W-1:0] need;

    always_comb
    begin
        eq_step   = (pos_reg != '0) && (adc == prev_reg);
        neq_step  = (pos_reg != '0) && (adc != prev_reg);
        steps_inc = (steps_reg != STEP_MAX) ? steps_reg + 1'b1 : steps_reg;
        need      = (min_equal_steps == '0) ? STEP_W'(1) : min_equal_steps;

        prev_next   = prev_reg;
        pos_next    = pos_reg;
        steps_next  = steps_reg;
        first_next  = first_reg;
        final_next  = final_reg;
        events_next = events_reg;

        if (eq_step && (steps_reg == '0))
        begin
            first_next = pos_reg - 1'b1;
        end
        if (eq_step)
        begin
            final_next = pos_reg;
        end
        close_steps = eq_step ? steps_inc : steps_reg;

        inc_next.valid  = sample_en && (neq_step || last) && (close_steps >= need);
        inc_next.run_lo = first_next;
        inc_next.run_hi = final_next;

        if (sample_en)
        begin
            prev_next  = adc;
            pos_next   = (pos_reg != POS_MAX) ? pos_reg + 1'b1 : pos_reg;
            steps_next = eq_step ? steps_inc : '0;
            if (last)
            begin
                pos_next   = '0;
                steps_next = '0;
            end
        end
        else
        begin
            first_next = first_reg;
            final_next = final_reg;
        end

        if (check_en)
        begin
            events_next = '0;
        end
        else if ((sample_en && last) || empty_en)
        begin
            if (events_reg != EVT_MAX)
            begin
                events_next = events_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= '0;
            pos_reg    <= '0;
            steps_reg  <= '0;
            first_reg  <= '0;
            final_reg  <= '0;
            events_reg <= '0;
            inc_reg    <= '0;
        end
        else
        begin
            prev_reg   <= prev_next;
            pos_reg    <= pos_next;
            steps_reg  <= steps_next;
            first_reg  <= first_next;
            final_reg  <= final_next;
            events_reg <= events_next;
            inc_reg    <= inc_next;
        end
    end

    assign run_inc     = inc_reg;
    assign event_total = events_reg;

endmodule

// ----- src/sarm_check.sv -----
`timescale 1ns / 1ps

module sarm_check (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sarm_pkg::EVT_W-1:0]    event_total,
    input  logic [sarm_pkg::LIM_W-1:0]    channels_in_use,
    input  logic [sarm_pkg::MINEV_W-1:0]  min_events,
    input  sarm_pkg::count_t              head_count,
    output sarm_pkg::chain_t              chain,
    output logic                          busy,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic                          crate_bad,
    output logic [1:0]                    group,
    output logic [63:0]                   bad_mask,
    output logic [8:0]                    bad_count,
    output logic                          last_group
);
    import sarm_pkg::*;

    chk_state_t          state_reg, state_next;
    logic [IDX_W-1:0]    cnt_reg, cnt_next;
    count_t              maxc_reg, maxc_next;
    logic [EVT_W-1:0]    events_reg, events_next;
    logic                bad_reg, bad_next;
    logic [MAX_CHANNELS-1:0] mask_reg, mask_next;
    logic [NBAD_W-1:0]   nbad_reg, nbad_next;
    logic [GRP_W-1:0]    grp_reg, grp_next;
    logic                out_valid_reg, out_valid_next;
    logic                crate_bad_reg, crate_bad_next;
    logic [1:0]          group_reg, group_next;
    logic [63:0]         mask_out_reg, mask_out_next;
    logic [8:0]          count_out_reg, count_out_next;
    logic                last_out_reg, last_out_next;

    logic                in_range;
    logic                pass_end;
    logic                hit;
    logic                out_load;
    logic [MASK_W-1:0]   mask_pad;
    logic [CMP_W-1:0]    head_x2;
    logic [CMP_W-1:0]    maxc_x2;

    always_comb
    begin
        in_range = LIM_W'(cnt_reg) < channels_in_use;
        pass_end = cnt_reg == IDX_W'(MAX_CHANNELS - 1);
        head_x2  = CMP_W'(head_count) << 1;
        maxc_x2  = CMP_W'(maxc_reg) << 1;
        hit      = bad_reg && in_range && (head_x2 >= CMP_W'(events_reg))
                   && (CMP_W'(head_count) >= CMP_W'(min_events));
        mask_pad = MASK_W'(mask_reg);
        out_load = 1'b0;

        state_next     = state_reg;
        cnt_next       = cnt_reg;
        maxc_next      = maxc_reg;
        events_next    = events_reg;
        bad_next       = bad_reg;
        mask_next      = mask_reg;
        nbad_next      = nbad_reg;
        grp_next       = grp_reg;
        chain.shift    = 1'b0;
        chain.wrap     = 1'b0;
        crate_bad_next = crate_bad_reg;
        group_next     = group_reg;
        mask_out_next  = mask_out_reg;
        count_out_next = count_out_reg;
        last_out_next  = last_out_reg;

        case (state_reg)
            CHK_IDLE:
            begin
                if (start)
                begin
                    events_next = event_total;
                    maxc_next   = '0;
                    cnt_next    = '0;
                    state_next  = CHK_MAX;
                end
            end
            CHK_MAX:
            begin
                chain.shift = 1'b1;
                chain.wrap  = 1'b1;
                if (in_range && (head_count > maxc_reg))
                begin
                    maxc_next = head_count;
                end
                cnt_next = cnt_reg + 1'b1;
                if (pass_end)
                begin
                    state_next = CHK_JUDGE;
                end
            end
            CHK_JUDGE:
            begin
                bad_next   = (maxc_x2 > CMP_W'(events_reg))
                             && (CMP_W'(maxc_reg) > CMP_W'(min_events));
                cnt_next   = '0;
                mask_next  = '0;
                nbad_next  = '0;
                state_next = CHK_MASK;
            end
            CHK_MASK:
            begin
                chain.shift        = 1'b1;
                mask_next[cnt_reg] = hit;
                nbad_next          = nbad_reg + NBAD_W'(hit);
                cnt_next           = cnt_reg + 1'b1;
                if (pass_end)
                begin
                    grp_next   = '0;
                    state_next = CHK_EMIT;
                end
            end
            CHK_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load       = 1'b1;
                    crate_bad_next = bad_reg;
                    group_next     = 2'(grp_reg);
                    mask_out_next  = mask_pad[grp_reg*64 +: 64];
                    count_out_next = 9'(nbad_reg);
                    last_out_next  = grp_reg == GROUP_LAST;
                    grp_next       = grp_reg + 1'b1;
                    if (grp_reg == GROUP_LAST)
                    begin
                        state_next = CHK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = CHK_IDLE;
            end
        endcase

        out_valid_next = out_load ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CHK_IDLE;
            cnt_reg       <= '0;
            grp_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            grp_reg       <= grp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        maxc_reg      <= maxc_next;
        events_reg    <= events_next;
        bad_reg       <= bad_next;
        mask_reg      <= mask_next;
        nbad_reg      <= nbad_next;
        crate_bad_reg <= crate_bad_next;
        group_reg     <= group_next;
        mask_out_reg  <= mask_out_next;
        count_out_reg <= count_out_next;
        last_out_reg  <= last_out_next;
    end

    assign busy       = state_reg != CHK_IDLE;
    assign out_valid  = out_valid_reg;
    assign crate_bad  = crate_bad_reg;
    assign group      = group_reg;
    assign bad_mask   = mask_out_reg;
    assign bad_count  = count_out_reg;
    assign last_group = last_out_reg;

endmodule

// ----- src/stuck_adc_run_monitor.sv -----
`timescale 1ns / 1ps

// Channel   Handshake             Payload
// input     in_valid / in_stall   command, adc, last
// output    out_valid / out_stall crate_bad, group, bad_mask, bad_count, last_group
// config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// Samples and empty events are taken one transaction per cycle while in_stall is low.
// A check rotates the count chain once past the head comparator for the
// maximum and shifts it once more past it for the masks, then sends four
// result transactions, one per cycle when out_stall stays low.
// Reset clears all counts at once; the block takes input as soon as reset is released.
// in_stall is high for the whole check; a waiting result holds its payload.

module stuck_adc_run_monitor (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    command,
    input  logic [11:0]                   adc,
    input  logic                          last,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          crate_bad,
    output logic [1:0]                    group,
    output logic [63:0]                   bad_mask,
    output logic [8:0]                    bad_count,
    output logic                          last_group,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sarm_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [sarm_pkg::CFG_DW-1:0]   cfg_data
);
    import sarm_pkg::*;

    logic [LIM_W-1:0]   channels_reg, channels_next;
    logic [STEP_W-1:0]  min_steps_reg, min_steps_next;
    logic [MINEV_W-1:0] min_events_reg, min_events_next;

    logic               accept;
    logic               busy;
    inc_t               run_inc;
    chain_t             chain;
    logic [EVT_W-1:0]   event_total;
    count_t             counts [MAX_CHANNELS];
    count_t             tail_in;

    assign cfg_ready = 1'b1;
    assign in_stall  = busy;
    assign accept    = in_valid && !busy;

    always_comb
    begin
        channels_next   = channels_reg;
        min_steps_next  = min_steps_reg;
        min_events_next = min_events_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CHANNELS:   channels_next   = cfg_data[LIM_W-1:0];
                CFG_MIN_STEPS:  min_steps_next  = cfg_data[STEP_W-1:0];
                CFG_MIN_EVENTS: min_events_next = cfg_data[MINEV_W-1:0];
                default:        channels_next   = channels_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channels_reg   <= CHANNELS_RESET;
            min_steps_reg  <= MIN_STEPS_RESET;
            min_events_reg <= MIN_EVENTS_RESET;
        end
        else
        begin
            channels_reg   <= channels_next;
            min_steps_reg  <= min_steps_next;
            min_events_reg <= min_events_next;
        end
    end

    sarm_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample_en       (accept && (command == CMD_SAMPLE)),
        .empty_en        (accept && (command == CMD_EMPTY)),
        .check_en        (accept && (command == CMD_CHECK)),
        .adc             (adc),
        .last            (last),
        .min_equal_steps (min_steps_reg),
        .run_inc         (run_inc),
        .event_total     (event_total)
    );

    assign tail_in = chain.wrap ? counts[0] : '0;

    for (genvar i = 0; i < MAX_CHANNELS; i++)
    begin : g_cell
        count_t next_count;
        if (i == MAX_CHANNELS - 1)
        begin : g_tail
            assign next_count = tail_in;
        end
        else
        begin : g_body
            assign next_count = counts[i+1];
        end

        sarm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .idx      (IDX_W'(i)),
            .limit    (channels_reg),
            .run_inc  (run_inc),
            .shift    (chain.shift),
            .shift_in (next_count),
            .count    (counts[i])
        );
    end

    sarm_check u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (accept && (command == CMD_CHECK)),
        .event_total     (event_total),
        .channels_in_use (channels_reg),
        .min_events      (min_events_reg),
        .head_count      (counts[0]),
        .chain           (chain),
        .busy            (busy),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .crate_bad       (crate_bad),
        .group           (group),
        .bad_mask        (bad_mask),
        .bad_count       (bad_count),
        .last_group      (last_group)
    );

endmodule

// ----- src/sarm_checker.sv -----
`timescale 1ns / 1ps

module sarm_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [1:0]                    command,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic                          crate_bad,
    input  logic [1:0]                    group,
    input  logic [63:0]                   bad_mask,
    input  logic [8:0]                    bad_count,
    input  logic                          last_group
);
    import sarm_pkg::*;

    a_check_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (command == CMD_CHECK) |=> in_stall)
        else $error("check transaction did not stall the input channel");

    a_good_crate_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !crate_bad |-> (bad_mask == '0) && (bad_count == '0))
        else $error("good crate reported bad channels");

    a_mask_within_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && crate_bad |-> bad_count >= 9'($countones(bad_mask)))
        else $error("group mask holds more channels than the total");

    a_last_group_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_group |-> group == 2'(GROUP_LAST))
        else $error("final transaction of a check on the wrong group");

    a_output_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(bad_mask) && $stable(group))
        else $error("stalled output transaction changed");

endmodule

bind stuck_adc_run_monitor sarm_checker u_sarm_checker (.*);
